@@ rtl/pulse_waveform_evaluator_top_assert.svh @@
// assertion macros for the pulse waveform evaluator checker
`ifndef PULSE_WAVEFORM_EVALUATOR_TOP_ASSERT_SVH
`define PULSE_WAVEFORM_EVALUATOR_TOP_ASSERT_SVH

// implication checked outside reset
`define PWE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwe check failed");

// next-cycle implication checked at every edge, reset included
`define PWE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pwe check failed");

`endif

@@ rtl/pwe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwe_pkg
// shared widths, codes and bundles of the pulse waveform evaluator
// ----------------------------------------------------------------------------
package pwe_pkg;

  localparam int TIME_WIDTH    = 32;
  localparam int LEVEL_WIDTH   = 16;
  localparam int QUO_WIDTH     = LEVEL_WIDTH + 1;
  localparam int PROD_WIDTH    = QUO_WIDTH + TIME_WIDTH;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int CFG_DAT_WIDTH = TIME_WIDTH;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_LOW_LEVEL     = 3'd0,
    CFG_HIGH_LEVEL    = 3'd1,
    CFG_DELAY_TIME    = 3'd2,
    CFG_RISE_TIME     = 3'd3,
    CFG_FALL_TIME     = 3'd4,
    CFG_PULSE_WIDTH   = 3'd5,
    CFG_PERIOD_LENGTH = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_DELAY   = 3'd0,
    PH_RISING  = 3'd1,
    PH_HIGH    = 3'd2,
    PH_FALLING = 3'd3,
    PH_LOW     = 3'd4
  } phase_t;

  typedef struct packed {
    logic                  valid;
    logic                  pre;
    logic [TIME_WIDTH-1:0] rem;
  } mod_res_t;

  typedef struct packed {
    logic                  valid;
    phase_t                phase;
    logic [PROD_WIDTH-1:0] prod;
    logic [TIME_WIDTH-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 valid;
    phase_t               phase;
    logic [QUO_WIDTH-1:0] quo;
  } div_res_t;

endpackage

@@ rtl/pwe_mod_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwe_mod_unit
// pipelined restoring remainder, one dividend bit per stage
// ----------------------------------------------------------------------------
module pwe_mod_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic                           in_pre,
  input  logic [pwe_pkg::TIME_WIDTH-1:0] in_dividend,
  input  logic [pwe_pkg::TIME_WIDTH-1:0] in_divisor,
  output pwe_pkg::mod_res_t              res
);
  import pwe_pkg::*;

  localparam int TW = TIME_WIDTH;

  logic [TW-1:0] rem_r   [TW];
  logic [TW-1:0] num_r   [TW];
  logic          valid_r [TW];
  logic          pre_r   [TW];

  for (genvar k = 0; k < TW; k++) begin : g_step
    logic [TW-1:0] prev_rem;
    logic [TW-1:0] prev_num;
    logic          prev_valid;
    logic          prev_pre;
    logic [TW:0]   trial;
    logic [TW:0]   diff;
    logic [TW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign prev_rem   = '0;
      assign prev_num   = in_dividend;
      assign prev_valid = in_valid;
      assign prev_pre   = in_pre;
    end else begin : g_next
      assign prev_rem   = rem_r[k-1];
      assign prev_num   = num_r[k-1];
      assign prev_valid = valid_r[k-1];
      assign prev_pre   = pre_r[k-1];
    end

    // shift in one dividend bit, subtract divisor when it fits
    always_comb begin
      trial   = {prev_rem, prev_num[TW-1]};
      diff    = trial - {1'b0, in_divisor};
      rem_nxt = (trial >= {1'b0, in_divisor}) ? diff[TW-1:0] : trial[TW-1:0];
    end

    // stage valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= prev_valid;
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        num_r[k] <= {prev_num[TW-2:0], 1'b0};
        pre_r[k] <= prev_pre;
      end
    end
  end

  assign res.valid = valid_r[TW-1];
  assign res.pre   = pre_r[TW-1];
  assign res.rem   = rem_r[TW-1];

endmodule

@@ rtl/pwe_div_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwe_div_unit
// pipelined ramp quotient, one quotient bit per stage
// ----------------------------------------------------------------------------
module pwe_div_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  pwe_pkg::div_req_t req,
  output pwe_pkg::div_res_t res
);
  import pwe_pkg::*;

  localparam int TW = TIME_WIDTH;
  localparam int QW = QUO_WIDTH;

  logic [TW-1:0] rem_r   [QW];
  logic [QW-1:0] low_r   [QW];
  logic [TW-1:0] den_r   [QW];
  logic [QW-1:0] quo_r   [QW];
  phase_t        phase_r [QW];
  logic          valid_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [TW-1:0] prev_rem;
    logic [QW-1:0] prev_low;
    logic [TW-1:0] prev_den;
    logic [QW-1:0] prev_quo;
    phase_t        prev_phase;
    logic          prev_valid;
    logic [TW:0]   trial;
    logic [TW:0]   diff;
    logic          fits;

    // product is below den times two to the quotient width, so the top part starts below den
    if (k == 0) begin : g_first
      assign prev_rem   = req.prod[PROD_WIDTH-1:QW];
      assign prev_low   = req.prod[QW-1:0];
      assign prev_den   = req.den;
      assign prev_quo   = '0;
      assign prev_phase = req.phase;
      assign prev_valid = req.valid;
    end else begin : g_next
      assign prev_rem   = rem_r[k-1];
      assign prev_low   = low_r[k-1];
      assign prev_den   = den_r[k-1];
      assign prev_quo   = quo_r[k-1];
      assign prev_phase = phase_r[k-1];
      assign prev_valid = valid_r[k-1];
    end

    // one restoring step
    always_comb begin
      trial = {prev_rem, prev_low[QW-1]};
      diff  = trial - {1'b0, prev_den};
      fits  = (trial >= {1'b0, prev_den});
    end

    // stage valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= prev_valid;
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]   <= fits ? diff[TW-1:0] : trial[TW-1:0];
        low_r[k]   <= {prev_low[QW-2:0], 1'b0};
        den_r[k]   <= prev_den;
        quo_r[k]   <= {prev_quo[QW-2:0], fits};
        phase_r[k] <= prev_phase;
      end
    end
  end

  assign res.valid = valid_r[QW-1];
  assign res.phase = phase_r[QW-1];
  assign res.quo   = quo_r[QW-1];

endmodule

@@ rtl/pulse_waveform_evaluator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_waveform_evaluator_top
// periodic trapezoidal pulse waveform evaluated at each requested time stamp
// ----------------------------------------------------------------------------
// usage
//   cfg port: write low/high level, delay, rise, fall, width and period by
//   index while no request is in flight; writes to unused indexes are dropped
//   in channel: in_valid / in_stall carry one time stamp per request
//   out channel: out_valid / out_stall carry level and phase, one per request
//   pipeline: 53 register stages, the 32-stage remainder pipeline and the
//   17-stage ramp quotient pipeline with the input, phase decode, product
//   and output registers
//   throughput: one request per cycle while the receiver does not stall
//   a stalled result freezes the whole pipeline and in_stall rises in the
//   same cycle; the held result stays on the output until taken
//   reset: configuration registers and valid flags clear, pipeline empties, no result pending
// ----------------------------------------------------------------------------
module pulse_waveform_evaluator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pwe_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [pwe_pkg::CFG_DAT_WIDTH-1:0] cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pwe_pkg::TIME_WIDTH-1:0]    in_time_stamp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pwe_pkg::LEVEL_WIDTH-1:0] out_level,
  output logic [2:0]                        out_phase
);
  import pwe_pkg::*;

  localparam int TW = TIME_WIDTH;
  localparam int LW = LEVEL_WIDTH;
  localparam int PW = PROD_WIDTH;

  // configuration registers
  logic [LW-1:0] low_level_r;
  logic [LW-1:0] high_level_r;
  logic [TW-1:0] delay_time_r;
  logic [TW-1:0] rise_time_r;
  logic [TW-1:0] fall_time_r;
  logic [TW-1:0] pulse_width_r;
  logic [TW-1:0] period_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_level_r     <= '0;
      high_level_r    <= '0;
      delay_time_r    <= '0;
      rise_time_r     <= '0;
      fall_time_r     <= '0;
      pulse_width_r   <= '0;
      period_length_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOW_LEVEL:     low_level_r     <= cfg_wdata[LW-1:0];
        CFG_HIGH_LEVEL:    high_level_r    <= cfg_wdata[LW-1:0];
        CFG_DELAY_TIME:    delay_time_r    <= cfg_wdata[TW-1:0];
        CFG_RISE_TIME:     rise_time_r     <= cfg_wdata[TW-1:0];
        CFG_FALL_TIME:     fall_time_r     <= cfg_wdata[TW-1:0];
        CFG_PULSE_WIDTH:   pulse_width_r   <= cfg_wdata[TW-1:0];
        CFG_PERIOD_LENGTH: period_length_r <= cfg_wdata[TW-1:0];
        default: ;
      endcase
    end
  end

  // global advance: pipeline moves unless a finished result is held
  logic en;
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // stage a: time since delay
  logic          valid_a_r;
  logic          pre_a_r;
  logic [TW-1:0] since_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (en) begin
      valid_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_a_r   <= (in_time_stamp < delay_time_r);
      since_a_r <= in_time_stamp - delay_time_r;
    end
  end

  // position within the period
  mod_res_t mod_res;

  pwe_mod_unit u_mod (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (valid_a_r),
    .in_pre      (pre_a_r),
    .in_dividend (since_a_r),
    .in_divisor  (period_length_r),
    .res         (mod_res)
  );

  // stage b: phase decode against widened segment ends
  logic [TW+1:0] e_rise;
  logic [TW+1:0] e_high;
  logic [TW+1:0] e_fall;
  logic [TW+1:0] pos_x;
  logic [TW+1:0] fall_off;
  phase_t        phase_nxt;
  logic [TW-1:0] num_nxt;
  logic [TW-1:0] den_nxt;

  always_comb begin
    e_rise    = {2'b00, rise_time_r};
    e_high    = e_rise + {2'b00, pulse_width_r};
    e_fall    = e_high + {2'b00, fall_time_r};
    pos_x     = {2'b00, mod_res.rem};
    fall_off  = pos_x - e_high;
    phase_nxt = PH_LOW;
    num_nxt   = '0;
    den_nxt   = {{(TW-1){1'b0}}, 1'b1};
    if (mod_res.pre) begin
      phase_nxt = PH_DELAY;
    end else if (period_length_r == '0) begin
      phase_nxt = PH_LOW;
    end else if (pos_x < e_rise) begin
      phase_nxt = PH_RISING;
      num_nxt   = mod_res.rem;
      den_nxt   = rise_time_r;
    end else if (pos_x < e_high) begin
      phase_nxt = PH_HIGH;
    end else if (pos_x < e_fall) begin
      phase_nxt = PH_FALLING;
      num_nxt   = fall_off[TW-1:0];
      den_nxt   = fall_time_r;
    end
  end

  logic          valid_b_r;
  phase_t        phase_b_r;
  logic [TW-1:0] num_b_r;
  logic [TW-1:0] den_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else if (en) begin
      valid_b_r <= mod_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phase_b_r <= phase_nxt;
      num_b_r   <= num_nxt;
      den_b_r   <= den_nxt;
    end
  end

  // stage c: level span magnitude times ramp position
  logic signed [LW:0] span;
  logic [LW:0]        span_mag;

  always_comb begin
    span     = $signed({high_level_r[LW-1], high_level_r})
             - $signed({low_level_r[LW-1], low_level_r});
    span_mag = span[LW] ? (~span + 1'b1) : span;
  end

  div_req_t div_req;
  div_res_t div_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_req.valid <= 1'b0;
    end else if (en) begin
      div_req.valid <= valid_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_req.phase <= phase_b_r;
      div_req.prod  <= PW'(span_mag) * PW'(num_b_r);
      div_req.den   <= den_b_r;
    end
  end

  pwe_div_unit u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .req   (div_req),
    .res   (div_res)
  );

  // output stage: apply ramp offset with the span sign
  logic signed [LW+1:0] quo_x;
  logic signed [LW+1:0] quo_s;
  logic signed [LW+1:0] low_x;
  logic signed [LW+1:0] high_x;
  logic signed [LW+1:0] level_x;
  logic [LW-1:0]        level_nxt;

  always_comb begin
    quo_x  = $signed({1'b0, div_res.quo});
    quo_s  = span[LW] ? -quo_x : quo_x;
    low_x  = $signed({{2{low_level_r[LW-1]}}, low_level_r});
    high_x = $signed({{2{high_level_r[LW-1]}}, high_level_r});
    case (div_res.phase)
      PH_RISING:  level_x = low_x + quo_s;
      PH_HIGH:    level_x = high_x;
      PH_FALLING: level_x = high_x - quo_s;
      default:    level_x = low_x;
    endcase
    level_nxt = level_x[LW-1:0];
  end

  logic [LW-1:0] out_level_r;
  phase_t        out_phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_level_r <= level_nxt;
      out_phase_r <= div_res.phase;
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = $signed(out_level_r);
  assign out_phase = out_phase_r;

endmodule

@@ rtl/pwe_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwe_checker
// port-level checks of the pulse waveform evaluator, bound to the top level
// ----------------------------------------------------------------------------
`include "pulse_waveform_evaluator_top_assert.svh"

module pwe_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [pwe_pkg::LEVEL_WIDTH-1:0] out_level,
  input logic [2:0]                            out_phase
);
  import pwe_pkg::*;

  // a held result keeps its payload
  `PWE_ASSERT_NEXT(a_out_hold, rst_n && out_valid && out_stall, out_valid && $stable(out_level) && $stable(out_phase))

  // input side stalls exactly while a result is held
  `PWE_ASSERT_IMPL(a_stall_link, 1'b1, in_stall == (out_valid && out_stall))

  // reset leaves no result pending
  `PWE_ASSERT_NEXT(a_reset_empty, !rst_n, !out_valid)

  // phase code stays within the five phases
  `PWE_ASSERT_IMPL(a_phase_range, out_valid, out_phase <= PH_LOW)

endmodule

bind pulse_waveform_evaluator_top pwe_checker u_pwe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_level (out_level),
  .out_phase (out_phase)
);
